>>> sv/salts_pkg.sv
// ----------------------------------------------------------------------------
// salts_pkg: shared types and constants for the set-associative tag store
// Field widths, outcome codes, transfer structs and sequencer states.
// ----------------------------------------------------------------------------
package salts_pkg;

  // fixed field widths
  localparam int TAG_BITS     = 20;
  localparam int SET_BITS     = 6;
  localparam int WAY_OUT_BITS = 2;
  localparam int SLOT_BITS    = 4;
  localparam int PADDR_BITS   = 3;

  // register map: the register index is paddr[2]
  localparam logic REG_VICTIM_SLOTS = 1'b0;
  localparam logic [SLOT_BITS-1:0] SLOTS_RESET = 4'd8;

  // access outcome codes
  typedef enum logic [2:0] {
    OC_HIT        = 3'd0,
    OC_VICTIM_HIT = 3'd1,
    OC_COLD       = 3'd2,
    OC_CAPACITY   = 3'd3,
    OC_CONFLICT   = 3'd4
  } outcome_t;

  // request transfer
  typedef struct packed {
    logic [SET_BITS-1:0] set_index;
    logic [TAG_BITS-1:0] tag;
  } req_t;

  // response transfer
  typedef struct packed {
    outcome_t                  outcome;
    logic [WAY_OUT_BITS-1:0]   way;
    logic                      evicted_valid;
    logic [TAG_BITS-1:0]       evicted_tag;
    logic                      victim_dropped;
  } rsp_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_LREAD,
    ST_LCHECK,
    ST_DECIDE,
    ST_VREAD,
    ST_VCHECK,
    ST_RESOLVE,
    ST_WRITE,
    ST_FINISH
  } state_t;

endpackage

>>> sv/salts_ram.sv
// ----------------------------------------------------------------------------
// salts_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module salts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/set_assoc_lru_tag_store_victim.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_tag_store_victim: LRU tag store with a victim buffer
// Looks up one access per request, updates LRU ages, moves tags between the
// tag store and the victim buffer and reports the access outcome.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake                         payload
//   req      in         req_valid / req_ready             req_t (set_index, tag)
//   rsp      out        rsp_valid / rsp_ready             rsp_t (outcome .. dropped)
//   apb      in         psel, penable, pwrite / pready    paddr, pwdata, prdata
//
// A hit reads each way of the set, decides, then writes each way back; a miss
// adds a scan over the active victim slots. A set_index >= SETS is first reduced
// by repeated subtraction of SETS. The tag store is read one way at a time
// through one shared line comparator; the victim scan uses a second comparator.
// After reset a clearing pass initializes every line of the tag store;
// req_ready stays low meanwhile. A new request is taken while a response still
// waits in the output register; the next response waits for it to drain.
// ----------------------------------------------------------------------------
module set_assoc_lru_tag_store_victim
  import salts_pkg::*;
#(
  parameter int SETS         = 64,
  parameter int WAYS         = 4,
  parameter int VICTIM_DEPTH = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  req_t                  req,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output rsp_t                  rsp,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int LINES   = SETS * WAYS;
  localparam int LINE_W  = $clog2(LINES);
  localparam int WAY_W   = $clog2(WAYS);
  localparam int AGE_W   = WAY_W;
  localparam int LWORD_W = 1 + AGE_W + TAG_BITS;
  localparam int VIDX_W  = (VICTIM_DEPTH > 1) ? $clog2(VICTIM_DEPTH) : 1;
  localparam int VCNT_W  = $clog2(VICTIM_DEPTH + 1);
  localparam int VWORD_W = TAG_BITS + SET_BITS;

  typedef struct packed {
    logic                valid;
    logic [AGE_W-1:0]    age;
    logic [TAG_BITS-1:0] tag;
  } lword_t;

  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic [SET_BITS-1:0] set_index;
  } vword_t;

  state_t state, state_next;

  // control registers
  logic [LINE_W-1:0]       clr_addr;
  logic [WAY_W-1:0]        wcnt;
  logic [VICTIM_DEPTH-1:0] vvalid;
  logic [SLOT_BITS-1:0]    slots_reg;

  // per-access registers
  logic [SET_BITS-1:0]  set_r;
  logic [TAG_BITS-1:0]  tag_r;
  logic                 lb_valid [WAYS];
  logic [AGE_W-1:0]     lb_age   [WAYS];
  logic [TAG_BITS-1:0]  lb_tag   [WAYS];
  logic                 hit_found;
  logic [WAY_W-1:0]     hit_way;
  logic [AGE_W-1:0]     hit_age;
  logic                 any_empty;
  logic                 lru_found;
  logic [WAY_W-1:0]     lru_way;
  logic                 lru_valid;
  logic [TAG_BITS-1:0]  lru_tag;
  logic [AGE_W-1:0]     lru_age;
  logic [VCNT_W-1:0]    vcnt;
  logic                 vhit_found;
  logic [VIDX_W-1:0]    vhit_idx;
  logic                 free_found;
  logic [VIDX_W-1:0]    free_idx;
  logic [WAY_W-1:0]     tgt_way;
  logic [AGE_W-1:0]     tgt_age;
  rsp_t                 res;

  // combinational signals
  logic [VCNT_W-1:0] slots;
  logic [VIDX_W-1:0] vidx;
  logic [LINE_W-1:0] line_base;
  logic [LINE_W-1:0] line_addr;
  logic              last_way;
  logic              line_we;
  logic [LINE_W-1:0] line_waddr;
  lword_t            line_wdata;
  lword_t            lrd;
  logic              line_match;
  logic              vic_we;
  vword_t            vic_wdata;
  vword_t            vrd;
  logic              vic_match;
  logic              rsp_load;
  logic              cfg_write;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[PADDR_BITS-1] == REG_VICTIM_SLOTS);
  assign prdata    = (paddr[PADDR_BITS-1] == REG_VICTIM_SLOTS) ? 32'(slots_reg) : '0;

  // effective slot count, saturated at the buffer depth
  assign slots = (32'(slots_reg) > VICTIM_DEPTH) ? VCNT_W'(VICTIM_DEPTH) : VCNT_W'(slots_reg);
  assign vidx  = vcnt[VIDX_W-1:0];

  // line addressing within the set
  assign line_base = LINE_W'(32'(set_r) * WAYS);
  assign line_addr = line_base + LINE_W'(wcnt);
  assign last_way  = (wcnt == WAY_W'(WAYS - 1));

  // shared comparators
  assign line_match = lrd.valid && (lrd.tag == tag_r);
  assign vic_match  = vvalid[vidx] && (vrd.set_index == set_r) && (vrd.tag == tag_r);
  assign rsp_load   = (state == ST_FINISH) && (!rsp_valid || rsp_ready);

  // tag store: valid, age and tag per line
  salts_ram #(
    .WIDTH (LWORD_W),
    .DEPTH (LINES)
  ) u_line_ram (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_waddr),
    .wdata (line_wdata),
    .raddr (line_addr),
    .rdata (lrd)
  );

  // victim buffer: tag and set per entry
  salts_ram #(
    .WIDTH (VWORD_W),
    .DEPTH (VICTIM_DEPTH)
  ) u_victim_ram (
    .clk   (clk),
    .we    (vic_we),
    .waddr (free_idx),
    .wdata (vic_wdata),
    .raddr (vidx),
    .rdata (vrd)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and control outputs
  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    line_we    = 1'b0;
    line_waddr = line_addr;
    line_wdata = '{valid: 1'b0, age: AGE_W'(wcnt), tag: '0};
    vic_we     = 1'b0;
    vic_wdata  = '{tag: lru_tag, set_index: set_r};
    unique case (state)
      ST_CLEAR: begin
        line_we    = 1'b1;
        line_waddr = clr_addr;
        if (clr_addr == LINE_W'(LINES - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          state_next = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (32'(set_r) < SETS) begin
          state_next = ST_LREAD;
        end
      end
      ST_LREAD: begin
        state_next = ST_LCHECK;
      end
      ST_LCHECK: begin
        state_next = last_way ? ST_DECIDE : ST_LREAD;
      end
      ST_DECIDE: begin
        state_next = hit_found ? ST_WRITE : ST_VREAD;
      end
      ST_VREAD: begin
        state_next = (vcnt == slots) ? ST_RESOLVE : ST_VCHECK;
      end
      ST_VCHECK: begin
        state_next = ST_VREAD;
      end
      ST_RESOLVE: begin
        vic_we     = !vhit_found && lru_valid && free_found;
        state_next = ST_WRITE;
      end
      ST_WRITE: begin
        line_we = 1'b1;
        if (wcnt == tgt_way) begin
          line_wdata = '{valid: 1'b1, age: AGE_W'(WAYS - 1), tag: tag_r};
        end else begin
          line_wdata.valid = lb_valid[wcnt];
          line_wdata.age   = (lb_age[wcnt] > tgt_age) ? lb_age[wcnt] - AGE_W'(1)
                                                      : lb_age[wcnt];
          line_wdata.tag   = lb_tag[wcnt];
        end
        if (last_way) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!rsp_valid || rsp_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers with reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      wcnt      <= '0;
      vvalid    <= '0;
      rsp_valid <= 1'b0;
      slots_reg <= SLOTS_RESET;
    end else begin
      if (cfg_write) begin
        slots_reg <= pwdata[SLOT_BITS-1:0];
      end
      // way counter steps through the set in clear, scan and write-back
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + LINE_W'(1);
          wcnt     <= last_way ? '0 : wcnt + WAY_W'(1);
        end
        ST_LCHECK, ST_WRITE: begin
          wcnt <= last_way ? '0 : wcnt + WAY_W'(1);
        end
        ST_REDUCE, ST_DECIDE, ST_RESOLVE: begin
          wcnt <= '0;
        end
        default: begin
        end
      endcase
      // victim entry freed on a victim hit, claimed on a push
      if (state == ST_RESOLVE) begin
        if (vhit_found) begin
          vvalid[vhit_idx] <= 1'b0;
        end else if (lru_valid && free_found) begin
          vvalid[free_idx] <= 1'b1;
        end
      end
      // response register handshake
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // per-access datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        set_r <= req.set_index;
        tag_r <= req.tag;
      end
      ST_REDUCE: begin
        if (32'(set_r) >= SETS) begin
          set_r <= set_r - SET_BITS'(SETS);
        end
      end
      ST_LCHECK: begin
        lb_valid[wcnt] <= lrd.valid;
        lb_age[wcnt]   <= lrd.age;
        lb_tag[wcnt]   <= lrd.tag;
        if (wcnt == '0) begin
          hit_found <= line_match;
          hit_way   <= wcnt;
          hit_age   <= lrd.age;
          any_empty <= !lrd.valid;
          lru_found <= (lrd.age == '0);
          lru_way   <= wcnt;
          lru_valid <= lrd.valid;
          lru_tag   <= lrd.tag;
          lru_age   <= lrd.age;
        end else begin
          if (line_match && !hit_found) begin
            hit_found <= 1'b1;
            hit_way   <= wcnt;
            hit_age   <= lrd.age;
          end
          if (!lrd.valid) begin
            any_empty <= 1'b1;
          end
          if (!lru_found && (lrd.age == '0)) begin
            lru_found <= 1'b1;
            lru_way   <= wcnt;
            lru_valid <= lrd.valid;
            lru_tag   <= lrd.tag;
            lru_age   <= lrd.age;
          end
        end
      end
      ST_DECIDE: begin
        vcnt       <= '0;
        vhit_found <= 1'b0;
        free_found <= 1'b0;
        tgt_way    <= hit_way;
        tgt_age    <= hit_age;
        res        <= '{outcome: OC_HIT, way: WAY_OUT_BITS'(hit_way), evicted_valid: 1'b0,
                        evicted_tag: '0, victim_dropped: 1'b0};
      end
      ST_VCHECK: begin
        vcnt <= vcnt + VCNT_W'(1);
        if (vic_match && !vhit_found) begin
          vhit_found <= 1'b1;
          vhit_idx   <= vidx;
        end
        if (!vvalid[vidx] && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= vidx;
        end
      end
      ST_RESOLVE: begin
        tgt_way           <= lru_way;
        tgt_age           <= lru_age;
        res.way           <= WAY_OUT_BITS'(lru_way);
        res.evicted_valid <= lru_valid;
        res.evicted_tag   <= lru_valid ? lru_tag : '0;
        if (vhit_found) begin
          res.outcome        <= OC_VICTIM_HIT;
          res.victim_dropped <= 1'b0;
        end else begin
          if (!lru_valid) begin
            res.outcome <= OC_COLD;
          end else if (any_empty) begin
            res.outcome <= OC_CAPACITY;
          end else begin
            res.outcome <= OC_CONFLICT;
          end
          res.victim_dropped <= lru_valid && !free_found;
        end
      end
      ST_FINISH: begin
        if (rsp_load) begin
          rsp <= res;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> sv/salts_chk.sv
// ----------------------------------------------------------------------------
// salts_chk: port-level checks for the tag store
// Watches the request and response transfers and the response fields.
// ----------------------------------------------------------------------------
module salts_chk
  import salts_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  // a waiting response holds until it is taken
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // one access at a time: no request right after an accepted one
  a_one_access: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while busy");

  // a tag store hit moves nothing
  a_hit_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.outcome == OC_HIT) |->
      !rsp.evicted_valid && !rsp.victim_dropped && (rsp.evicted_tag == '0))
    else $error("hit reports an eviction");

  // a drop only follows the eviction of a valid line on a capacity or conflict miss
  a_drop_cause: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.victim_dropped |->
      rsp.evicted_valid && ((rsp.outcome == OC_CAPACITY) || (rsp.outcome == OC_CONFLICT)))
    else $error("victim drop without eviction");

  // a cold miss fills an empty way
  a_cold_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.outcome == OC_COLD) |-> !rsp.evicted_valid && !rsp.victim_dropped)
    else $error("cold miss evicted a line");

endmodule

bind set_assoc_lru_tag_store_victim salts_chk u_salts_chk (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
